### hdl/sis_pkg.sv
// Shared constants, codes and types of the sorted identifier set.
package sis_pkg;

    // Store geometry.
    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths that the channels carry.
    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 7;

    // Operation codes. The unused code behaves as a membership test.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_CHANGED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic load_flags;
        logic do_insert;
        logic do_erase;
    } cell_ctrl_t;

endpackage

### hdl/sis_req_if.sv
// Request channel: operation and key with valid/ready handshake.
interface sis_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

### hdl/sis_rsp_if.sv
// Result channel: status, present flag, rank and count with valid/ready handshake.
interface sis_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       present;
    logic [6:0] rank;
    logic [6:0] count;

    modport source (output valid, output status, output present, output rank,
                    output count, input ready);
    modport sink   (input valid, input status, input present, input rank,
                    input count, output ready);
endinterface

### hdl/sorted_id_set.sv
// Top level of the sorted identifier set: controller, cell chain and result register.
// A result is registered once its request has passed the compare state and then the apply state.
// The apply step waits while the previous result has not been taken yet.
// Requests: a new request is taken only in the idle state, once the previous one has passed
// the compare and apply states; it is taken even while the previous result still waits.
// Reset: asynchronous active-low reset empties the set at once by clearing every
// cell's valid bit and the fill count; stored keys themselves are not cleared.
module sorted_id_set (
    input  logic     clk,
    input  logic     rst_n,
    sis_req_if.sink  req,
    sis_rsp_if.source rsp
);
    import sis_pkg::*;

    // Controller state and the captured request.
    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                present_reg, present_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic [RANK_W-1:0]   count_reg, count_next;

    // Chain signals. Index CAPACITY on the right edge and the left input of cell 0
    // are the fixed edge conditions of the chain.
    logic [KEY_BITS-1:0] entry_vec [CAPACITY+1];
    logic [CAPACITY:0]   valid_vec;
    logic [CAPACITY:0]   lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] bnd_vec;

    cell_ctrl_t          ctrl;
    logic                accept;
    logic                apply_fire;
    logic                hit;
    logic                any_bnd;
    logic [CNT_W-1:0]    rank_or;
    logic [CNT_W-1:0]    rank_full;
    logic                do_ins;
    logic                do_ers;

    assign accept = req.valid && req.ready;

    // The apply step may only complete when the result register is free or drains now.
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || rsp.ready);

    // The cell chain. Each cell sees its left neighbor for an insert shift and its
    // right neighbor for an erase shift.
    assign lt_vec[CAPACITY]    = 1'b0;
    assign valid_vec[CAPACITY] = 1'b0;
    assign entry_vec[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                left_lt_w;
        logic [KEY_BITS-1:0] left_entry_w;
        logic                left_valid_w;

        if (i == 0)
        begin : g_first
            assign left_lt_w    = 1'b1;
            assign left_entry_w = '0;
            assign left_valid_w = 1'b0;
        end
        else
        begin : g_rest
            assign left_lt_w    = lt_vec[i-1];
            assign left_entry_w = entry_vec[i-1];
            assign left_valid_w = valid_vec[i-1];
        end

        sis_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .key         (key_reg),
            .left_lt     (left_lt_w),
            .left_entry  (left_entry_w),
            .left_valid  (left_valid_w),
            .right_entry (entry_vec[i+1]),
            .right_valid (valid_vec[i+1]),
            .entry       (entry_vec[i]),
            .valid       (valid_vec[i]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i]),
            .bnd         (bnd_vec[i])
        );
    end

    // At most one cell matches and exactly one cell marks the boundary, unless every
    // cell holds a smaller key; the rank is then the full capacity.
    always_comb
    begin
        rank_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (bnd_vec[i])
            begin
                rank_or = rank_or | CNT_W'(i);
            end
        end
    end

    assign hit       = |eq_vec;
    assign any_bnd   = |bnd_vec;
    assign rank_full = any_bnd ? rank_or : CNT_W'(CAPACITY);

    assign do_ins = (op_reg == OP_INSERT) && !hit && (fill_reg != CNT_W'(CAPACITY));
    assign do_ers = (op_reg == OP_ERASE) && hit;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        req.ready       = 1'b0;
        ctrl.load_flags = 1'b0;
        ctrl.do_insert  = 1'b0;
        ctrl.do_erase   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_CMP:
            begin
                ctrl.load_flags = 1'b1;
            end
            S_APPLY:
            begin
                ctrl.do_insert = apply_fire && do_ins;
                ctrl.do_erase  = apply_fire && do_ers;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Request capture, fill count and result register.
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        present_next   = present_reg;
        rank_next      = rank_reg;
        count_next     = count_reg;

        if (accept)
        begin
            op_next  = req.operation;
            key_next = req.key[KEY_BITS-1:0];
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (apply_fire)
        begin
            if (do_ins)
            begin
                fill_next   = fill_reg + CNT_W'(1);
                status_next = ST_CHANGED;
            end
            else if (do_ers)
            begin
                fill_next   = fill_reg - CNT_W'(1);
                status_next = ST_CHANGED;
            end
            else if ((op_reg == OP_INSERT) && !hit)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_UNCHANGED;
            end
            out_valid_next = 1'b1;
            present_next   = hit;
            rank_next      = RANK_W'(rank_full);
            count_next     = RANK_W'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        present_reg <= present_next;
        rank_reg    <= rank_next;
        count_reg   <= count_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = status_reg;
    assign rsp.present = present_reg;
    assign rsp.rank    = rank_reg;
    assign rsp.count   = count_reg;

    // The fill count never passes the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // Valid cells form a prefix of the chain and their number is the fill count.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec[CAPACITY-1:0] & (valid_vec[CAPACITY-1:0] + CAPACITY'(1))) == '0)
        && ($countones(valid_vec[CAPACITY-1:0]) == int'(fill_reg)))
        else $error("valid cells are not a prefix matching the fill count");

    // No key is stored twice, so at most one cell matches during apply.
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(eq_vec))
        else $error("more than one cell matches the key");

    // A result only appears after an apply step.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_APPLY)
        else $error("result raised outside the apply step");

    // An insert that changed the set leaves the count one higher than before.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_fire && do_ins) |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("insert did not grow the fill count by one");

endmodule

### hdl/sis_cell.sv
// One storage cell of the sorted chain: holds one key, compares and shifts.
module sis_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sis_pkg::cell_ctrl_t              ctrl,
    input  logic [sis_pkg::KEY_BITS-1:0]     key,
    input  logic                             left_lt,
    input  logic [sis_pkg::KEY_BITS-1:0]     left_entry,
    input  logic                             left_valid,
    input  logic [sis_pkg::KEY_BITS-1:0]     right_entry,
    input  logic                             right_valid,
    output logic [sis_pkg::KEY_BITS-1:0]     entry,
    output logic                             valid,
    output logic                             lt,
    output logic                             eq,
    output logic                             bnd
);
    import sis_pkg::*;

    logic [KEY_BITS-1:0] entry_reg, entry_next;
    logic                valid_reg, valid_next;
    logic                lt_reg, lt_next;
    logic                eq_reg, eq_next;

    // The boundary cell is the first one whose key is not smaller.
    assign bnd = !lt_reg && left_lt;

    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.load_flags)
        begin
            lt_next = valid_reg && (entry_reg < key);
            eq_next = valid_reg && (entry_reg == key);
        end
        if (ctrl.do_insert && !lt_reg)
        begin
            if (left_lt)
            begin
                entry_next = key;
                valid_next = 1'b1;
            end
            else
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
        end
        else if (ctrl.do_erase && !lt_reg)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

### test/sis_set_monitor.sv
// Monitor that models the sorted identifier set and checks every result transfer.
`timescale 1ns / 100ps

module sis_set_monitor (
    input  logic clk,
    input  logic rst_n,
    sis_req_if   req,
    sis_rsp_if   rsp,
    output int   errors,
    output int   pending,
    output int   checked,
    output int   refused,
    output int   peak_fill
);
    import sis_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                present;
        logic [RANK_W-1:0]   rank;
        logic [RANK_W-1:0]   count;
    } set_answer_t;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

    // Model of the store: the first held_n words are valid, in ascending order.
    logic [KEY_W-1:0] held_ids [CAPACITY];
    int               held_n = 0;
    set_answer_t      pending_answers [$];
    set_answer_t      want;

    initial
    begin
        errors    = 0;
        pending   = 0;
        checked   = 0;
        refused   = 0;
        peak_fill = 0;
    end

    // Applies one operation to the model and returns the answer it gives.
    function automatic set_answer_t apply_to_set(logic [OP_W-1:0] op, logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] id;
        int               n;
        int               pos;
        bit               hit;
        set_answer_t      ans;
        id  = raw & KEY_MASK;
        n   = held_n;
        pos = 0;
        while (pos < n && held_ids[pos] < id)
            pos++;
        hit        = (pos < n) && (held_ids[pos] == id);
        ans.status = ST_UNCHANGED;
        if (op == OP_INSERT && !hit)
        begin
            if (n >= CAPACITY)
                ans.status = ST_FULL;
            else
            begin
                for (int i = n; i > pos; i--)
                    held_ids[i] = held_ids[i - 1];
                held_ids[pos] = id;
                n++;
                ans.status = ST_CHANGED;
            end
        end
        else if (op == OP_ERASE && hit)
        begin
            for (int i = pos; i + 1 < n; i++)
                held_ids[i] = held_ids[i + 1];
            n--;
            ans.status = ST_CHANGED;
        end
        held_n      = n;
        ans.present = hit;
        ans.rank    = pos[RANK_W-1:0];
        ans.count   = n[RANK_W-1:0];
        return ans;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] set monitor: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Results are handled before requests so a result never meets its own request.
            if (rsp.valid && rsp.ready)
            begin
                if (pending_answers.size() == 0)
                    flag_mismatch("result transfer with no request outstanding");
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp.status !== want.status)
                        flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                                checked, rsp.status, want.status));
                    if (rsp.present !== want.present)
                        flag_mismatch($sformatf("result %0d present %0b, want %0b",
                                                checked, rsp.present, want.present));
                    if (rsp.rank !== want.rank)
                        flag_mismatch($sformatf("result %0d rank %0d, want %0d",
                                                checked, rsp.rank, want.rank));
                    if (rsp.count !== want.count)
                        flag_mismatch($sformatf("result %0d count %0d, want %0d",
                                                checked, rsp.count, want.count));
                    checked++;
                end
            end
            if (req.valid && req.ready)
            begin
                want = apply_to_set(req.operation, req.key);
                if (want.status == ST_FULL)
                    refused++;
                if (held_n > peak_fill)
                    peak_fill = held_n;
                // The expected answer joins the tail of the queue.
                pending_answers = {pending_answers, want};
            end
            pending = pending_answers.size();
        end
    end

endmodule

### test/tb_sorted_id_set.sv
// Top of the sorted identifier set testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_sorted_id_set;
    import sis_pkg::*;

    // The fourth operation code has no name in the package; the block treats it
    // as a membership test, so it gets a name here to be sent on purpose.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Longest run of cycles with no transfer on either channel before giving up.
    // A correct block keeps transfers moving even under heavy stalls.
    localparam int STALL_LIMIT = 4000;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] KEY_TOP = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_ODD = {(KEY_W/2){2'b01}};
    localparam logic [KEY_W-1:0] KEY_EVN = {(KEY_W/2){2'b10}};

    localparam int ROUNDS     = 5;
    localparam int GROW_OPS   = 260;
    localparam int SHRINK_OPS = 140;
    localparam int POOL_SIZE  = 96;

    logic clk;
    logic rst_n;

    // When set, neither side inserts idle cycles: the block runs at full rate.
    bit   steady;
    int   quiet_cycles;

    int   errors;
    int   pending;
    int   checked;
    int   refused;
    int   peak_fill;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    sis_req_if req ();
    sis_rsp_if rsp ();

    sorted_id_set dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    sis_set_monitor monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .refused   (refused),
        .peak_fill (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = ~clk;
    end

    // The result side stalls about a third of the time, except in steady stretches.
    always @(negedge clk)
    begin
        rsp.ready <= steady || ($urandom_range(99) >= 34);
    end

    // Watchdog: a hung handshake on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: %0d cycles without a transfer", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one request, called at a falling edge. Random idle cycles come first,
    // then valid is held until the block takes the transfer. Returns at a falling
    // edge so the next request can follow without valid dropping in between.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] id);
        while (!steady && $urandom_range(99) < 34)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.key       <= id;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Picks an operation with weights that either fill or drain the set.
    function automatic logic [OP_W-1:0] pick_operation(input bit growing);
        int roll;
        roll = $urandom_range(99);
        if (roll < (growing ? 70 : 15))
            return OP_INSERT;
        if (roll < (growing ? 82 : 75))
            return OP_ERASE;
        if (roll < 95)
            return OP_LOOKUP;
        return OP_SPARE;
    endfunction

    // Most keys come from the round's pool so that hits are common; the rest
    // are fresh and, once the set is full, drive the refused-insert path.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 85)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return random_key();
    endfunction

    // The pool is larger than the store so that growth runs into the capacity.
    // It mixes full-width keys with keys packed near both ends of the range.
    task automatic fill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            case (i % 3)
                0: key_pool[i] = random_key();
                1: key_pool[i] = KEY_W'($urandom_range(255));
                default: key_pool[i] = KEY_MAX - KEY_W'($urandom_range(255));
            endcase
        end
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        steady        = 1'b0;
        quiet_cycles  = 0;
        req.valid     = 1'b0;
        req.operation = OP_INSERT;
        req.key       = '0;
        rsp.ready     = 1'b0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. An empty set answers lookups and erases, including the
        // spare code; then the key extremes go in, a duplicate insert is
        // rejected, absent and present erases are mixed, and the set is emptied.
        send_request(OP_LOOKUP, '0);
        send_request(OP_ERASE,  KEY_W'(5));
        send_request(OP_SPARE,  KEY_MAX);
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, KEY_TOP);
        send_request(OP_INSERT, '0);
        send_request(OP_LOOKUP, KEY_MAX);
        send_request(OP_SPARE,  KEY_TOP);
        send_request(OP_LOOKUP, KEY_TOP - KEY_W'(1));
        send_request(OP_ERASE,  KEY_TOP);
        send_request(OP_ERASE,  KEY_TOP);
        send_request(OP_INSERT, KEY_ODD);
        send_request(OP_INSERT, KEY_EVN);
        send_request(OP_ERASE,  KEY_MAX);
        send_request(OP_ERASE,  '0);
        send_request(OP_LOOKUP, KEY_EVN);
        send_request(OP_SPARE,  KEY_MAX);
        send_request(OP_INSERT, KEY_W'(1));
        send_request(OP_ERASE,  KEY_ODD);
        send_request(OP_ERASE,  KEY_EVN);
        send_request(OP_ERASE,  KEY_W'(1));

        // Random part. Each round grows the set until it is full and inserts are
        // refused, then drains it again. The second round runs without idling.
        for (int round = 0; round < ROUNDS; round++)
        begin
            fill_pool();
            steady = (round == 1);
            for (int n = 0; n < GROW_OPS; n++)
                send_request(pick_operation(1'b1), pick_key());
            for (int n = 0; n < SHRINK_OPS; n++)
                send_request(pick_operation(1'b0), pick_key());
        end
        steady = 1'b0;
        req.valid <= 1'b0;

        // Drain: every outstanding result must come back, then the bench keeps watching
        // to catch any stray result.
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Checked %0d results; %0d inserts refused on a full store.",
                 checked, refused);
        $display("Largest set size reached: %0d of %0d entries; %0d mismatches.",
                 peak_fill, CAPACITY, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
hdl/sis_pkg.sv
hdl/sis_req_if.sv
hdl/sis_rsp_if.sv
hdl/sis_cell.sv
hdl/sorted_id_set.sv
test/sis_set_monitor.sv
test/tb_sorted_id_set.sv
